// File: rtl/core/ffha_pkg.sv
// Package for the first-fit heap allocator: payload word types and codes.
// No dependencies.
package ffha_pkg;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic        action;
    logic [23:0] request_bytes;
    logic [63:0] release_address;
  } ffha_in_t;

  typedef struct packed {
    logic [63:0] granted_address;
    logic [1:0]  status;
    logic [23:0] used_bytes;
    logic [22:0] free_bytes;
  } ffha_out_t;

endpackage

// File: rtl/core/first_fit_heap_allocator_top.sv
// First-fit heap allocator top level: sequencer over a block table RAM.
// Depends on ffha_pkg and ffha_ram.
//
// Usage: one input word (alloc or free) on in_valid/in_ready, one result word
// on out_valid/out_ready. The heap start address is written through
// cfg_we/cfg_data; the user must write it only while idle, as the block does
// not enforce this. The block table lives in one RAM with registered read;
// entry k holds {free mark, payload size}. The sequencer walks the table entry
// by entry, issuing the read address and then checking the data. A split then
// shifts the tail up one entry (read j-1, write j per moved entry) and writes
// the hit and rest entries. A free that hits entry k treats that entry as free
// during one compaction pass over the whole table that merges free runs. A
// word refused at accept (null, out of range, zero size) goes straight to the
// output state. Used and free totals are kept in registers and updated as the
// table changes. One word is in work at a time: in_ready is low from accept
// until the result is taken. The result waits in an output register while
// out_ready is low. Reset (synchronous, rst high) clears control state; entry 0
// of the table is written in an init state right after reset, before the first
// word is taken, and no other entry is read before it is written.
module first_fit_heap_allocator_top
  import ffha_pkg::*;
#(
  parameter int HEAP_BYTES   = 8388608,
  parameter int MAX_BLOCKS   = 256,
  parameter int HEADER_BYTES = 24
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  ffha_in_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output ffha_out_t  out_data,
  input  logic       cfg_we,
  input  logic [63:0] cfg_data
);
  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);
  localparam logic [24:0] HDR = 25'(HEADER_BYTES);
  localparam logic [23:0] INIT_PAY = 24'(HEAP_BYTES - HEADER_BYTES);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SRD   = 4'd2;  // search: read issued
  localparam logic [3:0] S_SCHK  = 4'd3;  // search: data in
  localparam logic [3:0] S_SHRD  = 4'd4;  // shift: read j-1
  localparam logic [3:0] S_SHWR  = 4'd5;  // shift: write j
  localparam logic [3:0] S_SPLIT = 4'd6;  // write the rest entry
  localparam logic [3:0] S_MRD   = 4'd7;  // merge: read i
  localparam logic [3:0] S_MWR   = 4'd8;  // merge: fold i
  localparam logic [3:0] S_MEND  = 4'd9;  // merge: flush last
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]    state;
  logic [63:0]   heap_start;
  ffha_in_t      req;
  logic [24:0]   need;
  logic [CW-1:0] idx, cnt, wptr;
  logic [24:0]   off;
  logic [24:0]   hit_pay;
  logic [CW-1:0] hit_idx;
  logic [24:0]   acc_pay;
  logic          acc_free, acc_have;
  logic [23:0]   used_sum;
  logic [24:0]   free_sum;
  logic [24:0]   rel;
  ffha_out_t     res;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [24:0]   wdata, rdata;
  logic          e_free;
  logic          e_mfree;
  logic [24:0]   e_pay;

  ffha_ram #(.WIDTH(25), .DEPTH(MAX_BLOCKS)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign e_free = rdata[24];
  // during compaction the released entry counts as free
  assign e_mfree = e_free || (idx == hit_idx);
  assign e_pay  = {1'b0, rdata[23:0]};
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data  = res;

  // RAM port control
  always_comb begin
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = idx[AW-1:0];
    case (state)
      S_INIT: begin
        we = 1'b1;
        wdata = {1'b1, INIT_PAY};
      end
      S_SHRD: raddr = AW'(idx - 1'b1);
      S_SHWR: begin
        we = 1'b1;
        waddr = idx[AW-1:0];
        wdata = rdata;
      end
      S_SPLIT: begin
        // shrink the hit entry, mark used; rest written next via hit_idx+1
        we = 1'b1;
        waddr = hit_idx[AW-1:0];
        wdata = {1'b0, need[23:0]};
      end
      S_MWR: begin
        if (acc_have && !(acc_free && e_mfree)) begin
          we = 1'b1;
          waddr = wptr[AW-1:0];
          wdata = {acc_free, acc_pay[23:0]};
        end
      end
      S_MEND: begin
        we = 1'b1;
        waddr = wptr[AW-1:0];
        wdata = {acc_free, acc_pay[23:0]};
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      heap_start <= 64'h8040_0000;
      cnt        <= CW'(1);
      used_sum   <= '0;
      free_sum   <= {1'b0, INIT_PAY};
      idx        <= '0;
    end else begin
      if (cfg_we) heap_start <= cfg_data;
      case (state)
        S_INIT: state <= S_IDLE;
        S_IDLE: begin
          if (in_valid) begin
            req  <= in_data;
            need <= ({1'b0, in_data.request_bytes} + 25'd7) & ~25'd7;
            idx  <= '0;
            off  <= '0;
            rel  <= 25'(in_data.release_address - heap_start);
            res.granted_address <= '0;
            res.status <= ST_REFUSED;
            if (in_data.action == ACT_ALLOC) begin
              state <= (in_data.request_bytes == '0) ? S_OUT : S_SRD;
            end else if (in_data.release_address == '0
                || in_data.release_address < heap_start
                || (in_data.release_address - heap_start) >= 64'(HEAP_BYTES)) begin
              state <= S_OUT;
            end else begin
              state <= S_SRD;
            end
          end
        end
        S_SRD: begin
          state <= (idx >= cnt) ? S_OUT : S_SCHK;
        end
        S_SCHK: begin
          if (req.action == ACT_ALLOC) begin
            if (e_free && e_pay >= need) begin
              hit_idx <= idx;
              hit_pay <= e_pay;
              if (e_pay >= need + HDR + 25'd8) begin
                if (cnt >= MAXC) begin
                  res.status <= ST_FULL;
                  state <= S_OUT;
                end else begin
                  res.granted_address <= heap_start + 64'(off) + 64'(HEADER_BYTES);
                  idx <= cnt;
                  state <= S_SHRD;
                end
              end else begin
                res.granted_address <= heap_start + 64'(off) + 64'(HEADER_BYTES);
                res.status <= ST_DONE;
                used_sum <= used_sum + 24'(e_pay + HDR);
                free_sum <= free_sum - e_pay;
                // write the used mark through the flush state
                wptr <= idx;
                acc_pay <= e_pay;
                acc_free <= 1'b0;
                state <= S_MEND;
              end
            end else begin
              off <= off + HDR + e_pay;
              idx <= idx + 1'b1;
              state <= S_SRD;
            end
          end else begin
            if (off + HDR == rel) begin
              res.status <= ST_DONE;
              if (!e_free) begin
                used_sum <= used_sum - 24'(e_pay + HDR);
                free_sum <= free_sum + e_pay;
              end
              // start compaction with entry idx overridden as free
              hit_idx <= idx;
              idx  <= '0;
              wptr <= '0;
              acc_have <= 1'b0;
              state <= S_MRD;
            end else begin
              off <= off + HDR + e_pay;
              idx <= idx + 1'b1;
              state <= S_SRD;
            end
          end
        end
        S_SHRD: begin
          if (idx > hit_idx + 1'b1) state <= S_SHWR;
          else state <= S_SPLIT;
        end
        S_SHWR: begin
          idx <= idx - 1'b1;
          state <= S_SHRD;
        end
        S_SPLIT: begin
          res.status <= ST_DONE;
          used_sum <= used_sum + 24'(need + HDR);
          free_sum <= free_sum - need - HDR;
          wptr <= hit_idx + 1'b1;
          acc_pay <= hit_pay - need - HDR;
          acc_free <= 1'b1;
          cnt <= cnt + 1'b1;
          idx <= cnt + 1'b1;
          state <= S_MEND;
        end
        S_MRD: begin
          state <= (idx >= cnt) ? S_MEND : S_MWR;
        end
        S_MWR: begin
          if (acc_have && acc_free && e_mfree) begin
            // a merge turns one header into free payload
            acc_pay  <= acc_pay + HDR + e_pay;
            free_sum <= free_sum + HDR;
          end else begin
            if (acc_have) wptr <= wptr + 1'b1;
            acc_pay  <= e_pay;
            acc_free <= e_mfree;
            acc_have <= 1'b1;
          end
          idx <= idx + 1'b1;
          state <= S_MRD;
        end
        S_MEND: begin
          if (req.action == ACT_FREE) cnt <= wptr + 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          res.used_bytes <= used_sum;
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (state != S_OUT) begin
        res.used_bytes <= used_sum;
        res.free_bytes <= free_sum[22:0];
      end
    end
  end
endmodule

// File: rtl/core/ffha_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/ffha_checker.sv
// Port-level checker for the first-fit heap allocator, bound to the top.
// Depends on ffha_pkg.
module ffha_checker
  import ffha_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input ffha_out_t out_data
);
  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word dropped");
  a_stat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status != 2'd3)
    else $error("bad status");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_DONE |-> out_data.granted_address == '0)
    else $error("address on refusal");
endmodule

bind first_fit_heap_allocator_top ffha_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// File: bench/tb.sv
// Testbench for first_fit_heap_allocator_top: directed table, then random alloc/free words,
// each result checked against a first-fit model or table. Depends on ffha_pkg and the RTL.
`timescale 1ns / 100ps

module tb;
  import ffha_pkg::*;

  localparam int HEAP_SZ   = 8388608;
  localparam int TBL_DEPTH = 256;
  localparam int HDR       = 24;
  localparam longint unsigned BASE_RST = 64'h80400000;
  localparam int LIMIT     = 20000;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_we;
  ffha_in_t in_data;
  ffha_out_t out_data;
  logic [63:0] cfg_data;

  first_fit_heap_allocator_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // Model of the block table
  logic [23:0] blk_size [TBL_DEPTH];
  logic        blk_free [TBL_DEPTH];
  int          blk_cnt;
  logic [63:0] base_addr;
  ffha_out_t   result_q [$];
  logic [63:0] granted_q [$];   // live addresses, used to pick frees
  int          errors, mism_seen, idle_cycles;
  int          snd_idle_pct, rcv_idle_pct;
  bit          hold_rcv;

  function automatic void heap_reset();
    blk_size[0] = 24'(HEAP_SZ - HDR);
    blk_free[0] = 1'b1;
    blk_cnt = 1;
  endfunction

  function automatic void merge_runs();
    int w;
    w = 0;
    for (int i = 0; i < blk_cnt; i++) begin
      if (w > 0 && blk_free[w-1] && blk_free[i])
        blk_size[w-1] = 24'(blk_size[w-1] + HDR + blk_size[i]);
      else begin
        blk_size[w] = blk_size[i];
        blk_free[w] = blk_free[i];
        w++;
      end
    end
    blk_cnt = w;
  endfunction

  // Predict one result word and update the table
  function automatic ffha_out_t heap_step(ffha_in_t w);
    ffha_out_t r;
    longint unsigned need, off, rel, u, f;
    r = '0;
    r.status = ST_REFUSED;
    off = 0;
    if (w.action == ACT_ALLOC) begin
      need = (longint'(w.request_bytes) + 7) & ~64'd7;
      if (w.request_bytes != 0) begin
        for (int i = 0; i < blk_cnt; i++) begin
          if (blk_free[i] && blk_size[i] >= need) begin
            if (blk_size[i] >= need + HDR + 8) begin
              if (blk_cnt >= TBL_DEPTH) begin
                r.status = ST_FULL;
                break;
              end
              for (int j = blk_cnt; j > i + 1; j--) begin
                blk_size[j] = blk_size[j-1];
                blk_free[j] = blk_free[j-1];
              end
              blk_size[i+1] = 24'(blk_size[i] - need - HDR);
              blk_free[i+1] = 1'b1;
              blk_size[i] = 24'(need);
              blk_cnt++;
            end
            blk_free[i] = 1'b0;
            r.granted_address = base_addr + off + HDR;
            r.status = ST_DONE;
            break;
          end
          off += HDR + blk_size[i];
        end
      end
    end else if (w.release_address != 0 && w.release_address >= base_addr) begin
      rel = w.release_address - base_addr;
      if (rel < HEAP_SZ) begin
        for (int i = 0; i < blk_cnt; i++) begin
          if (off + HDR == rel) begin
            blk_free[i] = 1'b1;
            merge_runs();
            r.status = ST_DONE;
            break;
          end
          off += HDR + blk_size[i];
        end
      end
    end
    u = 0;
    f = 0;
    for (int i = 0; i < blk_cnt; i++)
      if (blk_free[i]) f += blk_size[i];
      else u += blk_size[i] + HDR;
    r.used_bytes = 24'(u);
    r.free_bytes = 23'(f);
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver with random stalls and an optional long hold-off
  always @(posedge clk) begin
    if (rst || hold_rcv) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Check results
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        errors++;
        if (mism_seen++ < 10) $display("unexpected result word %h", out_data);
      end else begin
        ffha_out_t e;
        e = result_q.pop_front();
        if (out_data !== e) begin
          errors++;
          if (mism_seen++ < 10)
            $display("mismatch: exp addr %h st %0d used %0d free %0d / got %h %0d %0d %0d",
                     e.granted_address, e.status, e.used_bytes, e.free_bytes,
                     out_data.granted_address, out_data.status, out_data.used_bytes,
                     out_data.free_bytes);
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Drive one word; expectations are pushed at accept time
  task automatic send_word(input ffha_in_t w);
    ffha_out_t r;
    do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    in_valid <= 1'b0;
    r = heap_step(w);
    result_q.push_back(r);
    if (r.status == ST_DONE && w.action == ACT_ALLOC) granted_q.push_back(r.granted_address);
  endtask

  task automatic drain();
    while (result_q.size() != 0) @(posedge clk);
    repeat (6 * TBL_DEPTH + 20) @(posedge clk);
  endtask

  task automatic set_base(input logic [63:0] b);
    cfg_we   <= 1'b1;
    cfg_data <= b;
    @(posedge clk);
    cfg_we <= 1'b0;
    base_addr = b;
    heap_reset_alloc_list();
  endtask

  // After a base change every outstanding block is freed first
  function automatic void heap_reset_alloc_list();
    granted_q.delete();
  endfunction

  task automatic free_all();
    ffha_in_t w;
    for (int i = 0; i < blk_cnt; i++) begin
      longint unsigned off;
      off = 0;
      for (int j = 0; j < i; j++) off += HDR + blk_size[j];
      if (!blk_free[i]) begin
        w = '0;
        w.action = ACT_FREE;
        w.release_address = base_addr + off + HDR;
        send_word(w);
        i = -1;
      end
    end
    granted_q.delete();
  endtask

  function automatic ffha_in_t rand_word();
    ffha_in_t w;
    int k;
    w = '0;
    k = $urandom_range(99);
    if (k < 55) begin
      w.action = ACT_ALLOC;
      case ($urandom_range(9))
        0: w.request_bytes = 24'($urandom());
        1: w.request_bytes = 24'($urandom_range(70000));
        default: w.request_bytes = 24'($urandom_range(300));
      endcase
    end else begin
      w.action = ACT_FREE;
      if (k < 90 && granted_q.size() > 0) begin
        int idx;
        idx = $urandom_range(granted_q.size() - 1);
        w.release_address = granted_q[idx];
        granted_q.delete(idx);
      end else begin
        w.release_address = {$urandom(), $urandom()};
        if (k < 95) w.release_address = base_addr + $urandom_range(HEAP_SZ);
      end
    end
    return w;
  endfunction

  typedef struct {
    logic        act;
    logic [23:0] req;
    logic [63:0] rel;
    bit          known;
    ffha_out_t   exp;
  } stim_row_t;

  stim_row_t dir_tbl [] = '{
    '{ACT_ALLOC, 24'd0, 64'd0, 1, '{64'd0, ST_REFUSED, 24'd0, 23'd8388584}},
    '{ACT_ALLOC, 24'hFFFFFF, 64'd0, 1, '{64'd0, ST_REFUSED, 24'd0, 23'd8388584}},
    '{ACT_FREE, 24'd0, 64'd0, 1, '{64'd0, ST_REFUSED, 24'd0, 23'd8388584}},
    '{ACT_FREE, 24'd0, 64'hFFFFFFFFFFFFFFFF, 1, '{64'd0, ST_REFUSED, 24'd0, 23'd8388584}},
    '{ACT_FREE, 24'd0, 64'h80400018, 1, '{64'd0, ST_DONE, 24'd0, 23'd8388584}},
    '{ACT_ALLOC, 24'd1, 64'd0, 1, '{64'h80400018, ST_DONE, 24'd32, 23'd8388552}},
    '{ACT_ALLOC, 24'd8388584, 64'd0, 0, '0},
    '{ACT_ALLOC, 24'd100, 64'd0, 0, '0},
    '{ACT_FREE, 24'd0, 64'h80400019, 0, '0},
    '{ACT_FREE, 24'd0, 64'h803FFFFF, 0, '0},
    '{ACT_FREE, 24'd0, 64'h80C00000, 0, '0},
    '{ACT_FREE, 24'd0, 64'h80400018, 0, '0},
    '{ACT_ALLOC, 24'd8388560, 64'd0, 0, '0},
    '{ACT_ALLOC, 24'd8, 64'd0, 0, '0},
    '{ACT_FREE, 24'd0, 64'h80400018, 0, '0},
    '{ACT_ALLOC, 24'd8388584, 64'd0, 0, '0},
    '{ACT_FREE, 24'd0, 64'h80400018, 0, '0}
  };

  initial begin
    ffha_in_t w;
    int phase_pct [4][2] = '{'{0, 0}, '{56, 0}, '{0, 56}, '{17, 17}};
    rst = 1; in_valid = 0; in_data = '0; cfg_we = 0; cfg_data = '0;
    out_ready = 0; hold_rcv = 0; errors = 0; mism_seen = 0; idle_cycles = 0;
    snd_idle_pct = 0; rcv_idle_pct = 0;
    base_addr = BASE_RST;
    heap_reset();
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed rows
    foreach (dir_tbl[i]) begin
      w = '0;
      w.action = dir_tbl[i].act;
      w.request_bytes = dir_tbl[i].req;
      w.release_address = dir_tbl[i].rel;
      send_word(w);
      if (dir_tbl[i].known) result_q[$] = dir_tbl[i].exp;
    end
    granted_q.delete();
    drain();
    free_all();
    drain();

    // Random phases across several base settings, extremes included
    for (int p = 0; p < 4; p++) begin
      logic [63:0] nb;
      case (p)
        0: nb = 64'd0;
        1: nb = 64'hFFFFFFFFFF7FFFFF;
        2: nb = {$urandom(), $urandom()} & 64'h7FFFFFFFFFFFFFF8;
        default: nb = BASE_RST;
      endcase
      set_base(nb);
      snd_idle_pct = phase_pct[p][0];
      rcv_idle_pct = phase_pct[p][1];
      // table-full pressure: many small allocs early in phase 0
      for (int n = 0; n < 140; n++) begin
        w = rand_word();
        if (p == 0 && n < 100) begin
          w = '0;
          w.action = ACT_ALLOC;
          w.request_bytes = 24'($urandom_range(1, 16));
          if (n > 90) w.request_bytes = 24'($urandom());
        end
        if (p == 1 && n == 50) begin
          fork
            begin
              hold_rcv <= 1'b1;
              repeat (3000) @(posedge clk);
              hold_rcv <= 1'b0;
            end
          join_none
        end
        send_word(w);
        if (n == 120) drain();
      end
      drain();
      free_all();
      drain();
    end

    if (errors == 0 && result_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/ffha_pkg.sv
rtl/core/ffha_ram.sv
rtl/core/first_fit_heap_allocator_top.sv
rtl/core/ffha_checker.sv
bench/tb.sv
